### src/cbz_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Color balance package
// Shared constants, register indexes and the configuration bundle type.
// ----------------------------------------------------------------------------
package cbz_pkg;

	localparam int FRAC_BITS_DEF = 16;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 24;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_SHADOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIDTONE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HIGHLIGHT = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PRESERVE  = 2'd3;

	localparam logic PRESERVE_RST = 1'b1;
	localparam logic [7:0] PIX_MAX = 8'hFF;

	// Luma weights in thousandths
	localparam int LUMA_KR = 299;
	localparam int LUMA_KG = 587;
	localparam int LUMA_KB = 114;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] shadow;
		logic [CFG_DATA_W-1:0] midtone;
		logic [CFG_DATA_W-1:0] highlight;
		logic                  preserve;
	} cbz_cfg_t;

endpackage
`default_nettype wire

### src/cbz_pix_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Input pixel channel
// Valid/ready channel carrying one RGB pixel.
// ----------------------------------------------------------------------------
interface cbz_pix_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;

	modport source (output valid, output red_in, output green_in, output blue_in,
		input ready);
	modport sink (input valid, input red_in, input green_in, input blue_in,
		output ready);
endinterface
`default_nettype wire

### src/cbz_pix_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Output pixel channel
// Valid/ready channel carrying one adjusted RGB pixel.
// ----------------------------------------------------------------------------
interface cbz_pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;

	modport source (output valid, output red_out, output green_out, output blue_out,
		input ready);
	modport sink (input valid, input red_out, input green_out, input blue_out,
		output ready);
endinterface
`default_nettype wire

### src/cbz_cfg_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface cbz_cfg_if;
	import cbz_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### src/cbz_luma.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Luma and zone weights
// Stages 1-4: channel to fixed point, luma sum, divide by 1000, zone weights.
// ----------------------------------------------------------------------------
module cbz_luma #(
	parameter int FRAC_BITS = cbz_pkg::FRAC_BITS_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      en,
	input  logic                      in_valid,
	input  logic [7:0]                red,
	input  logic [7:0]                green,
	input  logic [7:0]                blue,
	output logic                      valid_s4,
	output logic [2:0][FRAC_BITS:0]   chan_s4,
	output logic [FRAC_BITS:0]        luma_s4,
	output logic [FRAC_BITS:0]        w_shadow_s4,
	output logic [FRAC_BITS:0]        w_mid_s4,
	output logic [FRAC_BITS:0]        w_high_s4
);
	import cbz_pkg::*;

	localparam int CW    = FRAC_BITS + 1;
	localparam int S255  = FRAC_BITS + 16;
	localparam int M255W = FRAC_BITS + 9;
	localparam logic [M255W-1:0] M255 =
		M255W'(((64'd1 << S255) + 64'd254) / 64'd255);
	localparam int XW    = FRAC_BITS + 10;
	localparam int YW    = XW - 3;
	localparam int S125  = FRAC_BITS + 14;
	localparam int M125W = FRAC_BITS + 8;
	localparam logic [M125W-1:0] M125 =
		M125W'(((64'd1 << S125) + 64'd124) / 64'd125);
	localparam logic [CW+1:0] ONE_X = (CW+2)'(64'd1 << FRAC_BITS);
	localparam logic [CW+1:0] TH_X  = (CW+2)'(64'd3 << (FRAC_BITS - 1));
	localparam logic [CW-1:0] HALF  = CW'(64'd1 << (FRAC_BITS - 1));

	logic [2:0][7:0] pix;
	assign pix = {blue, green, red};

	// Stage 1: ceil(p * one / 255) by reciprocal multiply
	logic                 v_s1;
	logic [2:0][CW-1:0]   chan_s1;
	logic [2:0][CW-1:0]   chan_d1;

	for (genvar i = 0; i < 3; i++) begin : g_conv
		logic [M255W+7:0] prod;
		logic             frac;
		assign prod = (M255W+8)'(pix[i]) * (M255W+8)'(M255);
		assign frac = (pix[i] != 8'd0) && (pix[i] != PIX_MAX);
		assign chan_d1[i] = prod[16 +: CW] + CW'(frac);
	end

	// Stage 2: weighted sum
	logic                 v_s2;
	logic [2:0][CW-1:0]   chan_s2;
	logic [XW-1:0]        lsum_s2;
	logic [XW-1:0]        lsum_d2;

	assign lsum_d2 = XW'(chan_s1[0]) * XW'(LUMA_KR) + XW'(chan_s1[1]) * XW'(LUMA_KG)
		+ XW'(chan_s1[2]) * XW'(LUMA_KB);

	// Stage 3: divide by 1000 as (x >> 3) / 125
	logic                 v_s3;
	logic [2:0][CW-1:0]   chan_s3;
	logic [CW-1:0]        luma_s3;
	logic [YW+M125W-1:0]  lprod;

	assign lprod = (YW+M125W)'(lsum_s2[XW-1:3]) * (YW+M125W)'(M125);

	// Stage 4: zone weights
	logic [CW+2:0] five;
	logic [CW+1:0] t;
	logic [CW-1:0] dev;
	logic [CW+1:0] d3;

	assign five = (CW+3)'({luma_s3, 2'b00}) + (CW+3)'(luma_s3);
	assign t    = five[CW+2:1];
	assign dev  = (luma_s3 >= HALF) ? luma_s3 - HALF : HALF - luma_s3;
	assign d3   = (CW+2)'({dev, 1'b0}) + (CW+2)'(dev);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			v_s2     <= 1'b0;
			v_s3     <= 1'b0;
			valid_s4 <= 1'b0;
		end else if (en) begin
			v_s1     <= in_valid;
			v_s2     <= v_s1;
			v_s3     <= v_s2;
			valid_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chan_s1     <= chan_d1;
			chan_s2     <= chan_s1;
			lsum_s2     <= lsum_d2;
			chan_s3     <= chan_s2;
			luma_s3     <= lprod[S125 +: CW];
			chan_s4     <= chan_s3;
			luma_s4     <= luma_s3;
			w_shadow_s4 <= (t < ONE_X) ? CW'(ONE_X - t) : '0;
			w_mid_s4    <= (d3 < ONE_X) ? CW'(ONE_X - d3) : '0;
			w_high_s4   <= (t > TH_X) ? CW'(t - TH_X) : '0;
		end
	end

endmodule
`default_nettype wire

### src/cbz_adjust.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Zone gain adjust
// Stages 5-9: gain sums, divide by 100, add, new luma, rescale decision.
// ----------------------------------------------------------------------------
module cbz_adjust #(
	parameter int FRAC_BITS = cbz_pkg::FRAC_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  cbz_pkg::cbz_cfg_t           cfg,
	input  logic                        valid_s4,
	input  logic [2:0][FRAC_BITS:0]     chan_s4,
	input  logic [FRAC_BITS:0]          luma_s4,
	input  logic [FRAC_BITS:0]          w_shadow_s4,
	input  logic [FRAC_BITS:0]          w_mid_s4,
	input  logic [FRAC_BITS:0]          w_high_s4,
	output logic                        valid_s9,
	output logic [2:0][FRAC_BITS+3:0]   adj_s9,
	output logic [FRAC_BITS:0]          luma_s9,
	output logic [FRAC_BITS+3:0]        den_s9,
	output logic                        rescale_s9
);
	import cbz_pkg::*;

	localparam int CW     = FRAC_BITS + 1;
	localparam int SW     = FRAC_BITS + 12;
	localparam int AW     = FRAC_BITS + 4;
	localparam int QAW    = FRAC_BITS + 2;
	localparam int Y6W    = FRAC_BITS + 7;
	localparam int S25    = FRAC_BITS + 12;
	localparam int M25W   = FRAC_BITS + 8;
	localparam logic [M25W-1:0] M25 = M25W'(((64'd1 << S25) + 64'd24) / 64'd25);
	localparam int NW     = FRAC_BITS + 14;
	localparam int Y9W    = NW - 4;
	localparam int NDW    = FRAC_BITS + 4;
	localparam int S125N  = FRAC_BITS + 17;
	localparam int M125NW = FRAC_BITS + 11;
	localparam logic [M125NW-1:0] M125N =
		M125NW'(((64'd1 << S125N) + 64'd124) / 64'd125);
	localparam logic [NDW-1:0] THR = NDW'((64'd1 << FRAC_BITS) / 64'd1000);
	localparam logic signed [NW-1:0] K_R = NW'(LUMA_KR);
	localparam logic signed [NW-1:0] K_G = NW'(LUMA_KG);
	localparam logic signed [NW-1:0] K_B = NW'(LUMA_KB);

	logic v_s5, v_s6, v_s7, v_s8;
	logic [2:0][CW-1:0]  chan_s5, chan_s6;
	logic [CW-1:0]       luma_s5, luma_s6, luma_s7, luma_s8;
	logic [2:0][SW-1:0]  sum_s5, sum_d5;
	logic [2:0][QAW-1:0] quo_s6, quo_d6;
	logic [2:0]          neg_s6;
	logic [2:0][AW-1:0]  adj_s7, adj_d7, adj_s8;
	logic [NW-1:0]       nsum_s8;
	logic signed [NW-1:0] nsum_d8;

	for (genvar i = 0; i < 3; i++) begin : g_chan
		// Stage 5: signed gain times zone weight, summed over zones
		logic signed [SW-1:0] gs, gm, gh, ws, wm, wh, sum;
		assign gs  = SW'($signed(cfg.shadow[8*i +: 8]));
		assign gm  = SW'($signed(cfg.midtone[8*i +: 8]));
		assign gh  = SW'($signed(cfg.highlight[8*i +: 8]));
		assign ws  = $signed(SW'(w_shadow_s4));
		assign wm  = $signed(SW'(w_mid_s4));
		assign wh  = $signed(SW'(w_high_s4));
		assign sum = gs * ws + gm * wm + gh * wh;
		assign sum_d5[i] = sum;

		// Stage 6: magnitude / 100 as (m >> 2) / 25, sign kept aside
		logic [SW-1:0]        mag;
		logic [Y6W+M25W-1:0]  qprod;
		assign mag    = sum_s5[i][SW-1] ? SW'(-$signed(sum_s5[i])) : sum_s5[i];
		assign qprod  = (Y6W+M25W)'(mag[FRAC_BITS+8:2]) * (Y6W+M25W)'(M25);
		assign quo_d6[i] = qprod[S25 +: QAW];

		// Stage 7: add truncated delta to the channel
		logic signed [AW-1:0] base, delta;
		assign base  = $signed(AW'(chan_s6[i]));
		assign delta = $signed(AW'(quo_s6[i]));
		assign adj_d7[i] = neg_s6[i] ? base - delta : base + delta;
	end

	// Stage 8: new luma numerator, signed
	logic signed [NW-1:0] e0, e1, e2;
	assign e0 = NW'($signed(adj_s7[0]));
	assign e1 = NW'($signed(adj_s7[1]));
	assign e2 = NW'($signed(adj_s7[2]));
	assign nsum_d8 = e0 * K_R + e1 * K_G + e2 * K_B;

	// Stage 9: new luma for positive sums, threshold test
	logic                 pos;
	logic [Y9W+M125NW-1:0] nprod;
	logic [NDW-1:0]       nluma;
	assign pos   = !nsum_s8[NW-1] && (nsum_s8 != '0);
	assign nprod = (Y9W+M125NW)'(nsum_s8[NW-2:3]) * (Y9W+M125NW)'(M125N);
	assign nluma = nprod[S125N +: NDW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5     <= 1'b0;
			v_s6     <= 1'b0;
			v_s7     <= 1'b0;
			v_s8     <= 1'b0;
			valid_s9 <= 1'b0;
		end else if (en) begin
			v_s5     <= valid_s4;
			v_s6     <= v_s5;
			v_s7     <= v_s6;
			v_s8     <= v_s7;
			valid_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			chan_s5    <= chan_s4;
			luma_s5    <= luma_s4;
			sum_s5     <= sum_d5;
			chan_s6    <= chan_s5;
			luma_s6    <= luma_s5;
			quo_s6     <= quo_d6;
			neg_s6     <= {sum_s5[2][SW-1], sum_s5[1][SW-1], sum_s5[0][SW-1]};
			adj_s7     <= adj_d7;
			luma_s7    <= luma_s6;
			adj_s8     <= adj_s7;
			luma_s8    <= luma_s7;
			nsum_s8    <= nsum_d8;
			adj_s9     <= adj_s8;
			luma_s9    <= luma_s8;
			den_s9     <= nluma;
			rescale_s9 <= cfg.preserve && pos && (nluma > THR);
		end
	end

endmodule
`default_nettype wire

### src/cbz_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined divider
// Restoring division of luma * one by new luma, one quotient bit per stage.
// ----------------------------------------------------------------------------
module cbz_div #(
	parameter int FRAC_BITS = cbz_pkg::FRAC_BITS_DEF,
	parameter int SIDE_W    = 1
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   in_valid,
	input  logic [FRAC_BITS:0]     luma,
	input  logic [FRAC_BITS+3:0]   den,
	input  logic [SIDE_W-1:0]      side_in,
	output logic                   out_valid,
	output logic [FRAC_BITS+9:0]   quot,
	output logic [SIDE_W-1:0]      side_out
);
	localparam int QW  = FRAC_BITS + 10;
	localparam int NDW = FRAC_BITS + 4;
	localparam int DW  = 2 * FRAC_BITS + 1;

	logic [DW-1:0] dvd;
	assign dvd = {luma, {FRAC_BITS{1'b0}}};

	logic [QW-1:0]             vld_s;
	logic [QW-1:0][NDW-1:0]    rem_s;
	logic [QW-1:0][NDW-1:0]    den_s;
	logic [QW-1:0][QW-1:0]     lo_s;
	logic [QW-1:0][QW-1:0]     quo_s;
	logic [QW-1:0][SIDE_W-1:0] side_s;

	for (genvar k = 0; k < QW; k++) begin : g_st
		logic              v_in;
		logic [NDW-1:0]    r_in, d_in;
		logic [QW-1:0]     lo_in, q_in;
		logic [SIDE_W-1:0] sd_in;
		logic [NDW:0]      trial, diff;
		logic              take;

		if (k == 0) begin : g_first
			// Top dividend bits stay below the divisor when the quotient fits
			assign v_in  = in_valid;
			assign r_in  = NDW'(dvd[DW-1:QW]);
			assign d_in  = den;
			assign lo_in = dvd[QW-1:0];
			assign q_in  = '0;
			assign sd_in = side_in;
		end else begin : g_next
			assign v_in  = vld_s[k-1];
			assign r_in  = rem_s[k-1];
			assign d_in  = den_s[k-1];
			assign lo_in = lo_s[k-1];
			assign q_in  = quo_s[k-1];
			assign sd_in = side_s[k-1];
		end

		assign trial = {r_in, lo_in[QW-1-k]};
		assign take  = trial >= {1'b0, d_in};
		assign diff  = trial - {1'b0, d_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]  <= take ? diff[NDW-1:0] : trial[NDW-1:0];
				den_s[k]  <= d_in;
				lo_s[k]   <= lo_in;
				quo_s[k]  <= q_in | (QW'(take) << (QW - 1 - k));
				side_s[k] <= sd_in;
			end
		end
	end

	assign out_valid = vld_s[QW-1];
	assign quot      = quo_s[QW-1];
	assign side_out  = side_s[QW-1];

endmodule
`default_nettype wire

### src/cbz_out.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Rescale and output
// Luma rescale multiply, clamp to 0..255, output register with skid slot.
// ----------------------------------------------------------------------------
module cbz_out #(
	parameter int FRAC_BITS = cbz_pkg::FRAC_BITS_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [FRAC_BITS+9:0]       quot,
	input  logic [2:0][FRAC_BITS+3:0]  adj,
	input  logic                       rescale,
	input  logic                       out_ready,
	output logic                       advance,
	output logic                       out_valid,
	output logic [2:0][7:0]            out_pix
);
	import cbz_pkg::*;

	localparam int CW = FRAC_BITS + 1;
	localparam int AW = FRAC_BITS + 4;
	localparam int QW = FRAC_BITS + 10;
	localparam int PW = AW + QW + 1;

	logic                 v_sm, v_sc;
	logic [2:0][PW-1:0]   prod_sm, prod_d;
	logic [2:0][AW-1:0]   adj_sm;
	logic                 resc_sm;
	logic [2:0]           zero_sc, sat_sc, zero_d, sat_d;
	logic [2:0][CW-1:0]   cf_sc, cf_d;
	logic [2:0][7:0]      res;

	for (genvar i = 0; i < 3; i++) begin : g_chan
		logic signed [PW-1:0] a_x, q_x;
		assign a_x = PW'($signed(adj[i]));
		assign q_x = $signed(PW'(quot));
		assign prod_d[i] = a_x * q_x;

		// Nonpositive goes to zero; positive value beyond two ones saturates
		always_comb begin
			if (resc_sm) begin
				zero_d[i] = prod_sm[i][PW-1] || (prod_sm[i] == '0);
				sat_d[i]  = |prod_sm[i][PW-2:2*FRAC_BITS+1];
				cf_d[i]   = prod_sm[i][2*FRAC_BITS:FRAC_BITS];
			end else begin
				zero_d[i] = adj_sm[i][AW-1] || (adj_sm[i] == '0);
				sat_d[i]  = |adj_sm[i][AW-2:FRAC_BITS+1];
				cf_d[i]   = adj_sm[i][FRAC_BITS:0];
			end
		end

		logic [CW+7:0] v255;
		logic [8:0]    o9;
		assign v255 = (CW+8)'({cf_sc[i], 8'b0}) - (CW+8)'(cf_sc[i]);
		assign o9   = v255[FRAC_BITS+8:FRAC_BITS];
		assign res[i] = zero_sc[i] ? 8'd0 : ((sat_sc[i] || o9[8]) ? PIX_MAX : o9[7:0]);
	end

	logic            out_v_q, skid_v_q;
	logic [2:0][7:0] out_px_q, skid_px_q;
	logic            push, pop;

	assign advance = !skid_v_q;
	assign push    = v_sc && advance;
	assign pop     = out_v_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_sm     <= 1'b0;
			v_sc     <= 1'b0;
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (advance) begin
				v_sm <= in_valid;
				v_sc <= v_sm;
			end
			if (!out_v_q || pop) begin
				out_v_q  <= skid_v_q || push;
				skid_v_q <= 1'b0;
			end else if (push) begin
				skid_v_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_sm <= prod_d;
			adj_sm  <= adj;
			resc_sm <= rescale;
			zero_sc <= zero_d;
			sat_sc  <= sat_d;
			cf_sc   <= cf_d;
		end
		if (!out_v_q || pop) begin
			out_px_q <= skid_v_q ? skid_px_q : res;
		end else if (push) begin
			skid_px_q <= res;
		end
	end

	assign out_valid = out_v_q;
	assign out_pix   = out_px_q;

endmodule
`default_nettype wire

### src/color_balance_three_zone_rgb.sv
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one pixel per clock unless the skid slot is full; the divider is fully
//   pipelined, one stage per quotient bit (FRAC_BITS + 10 stages), so nothing iterates.
// Stall: an output register plus one skid slot; the pipeline holds only when both
//   are full. Reset clears all valid bits and loads gains 0, preserve_luma 1.
// ----------------------------------------------------------------------------
// Three-zone RGB color balance
// Shadow / midtone / highlight percent gains with optional luma preservation.
// ----------------------------------------------------------------------------
module color_balance_three_zone_rgb #(
	parameter int FRAC_BITS = cbz_pkg::FRAC_BITS_DEF
) (
	input wire logic       clk,
	input wire logic       arst_n,
	cbz_pix_in_if.sink     upstream,
	cbz_pix_out_if.source  downstream,
	cbz_cfg_if.sink        cfg
);
	import cbz_pkg::*;

	localparam int CW     = FRAC_BITS + 1;
	localparam int AW     = FRAC_BITS + 4;
	localparam int NDW    = FRAC_BITS + 4;
	localparam int QW     = FRAC_BITS + 10;
	localparam int SIDE_W = 3 * AW + 1;

	// ------------------------------------------------------------------
	// Configuration registers. Writes are always taken; out-of-range
	// indexes cannot occur with a two-bit index.
	// ------------------------------------------------------------------
	cbz_cfg_t cfg_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.shadow    <= '0;
			cfg_q.midtone   <= '0;
			cfg_q.highlight <= '0;
			cfg_q.preserve  <= PRESERVE_RST;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_SHADOW: begin
					cfg_q.shadow <= cfg.data;
				end
				REG_MIDTONE: begin
					cfg_q.midtone <= cfg.data;
				end
				REG_HIGHLIGHT: begin
					cfg_q.highlight <= cfg.data;
				end
				REG_PRESERVE: begin
					cfg_q.preserve <= cfg.data[0];
				end
				default: begin
				end
			endcase
		end
	end

	// ------------------------------------------------------------------
	// One global advance strobe: every stage moves together, and holds
	// only when the skid slot behind the output register is occupied.
	// ------------------------------------------------------------------
	logic advance;

	assign upstream.ready = advance;

	// Stages 1-4: convert, luma, zone weights
	logic                valid_s4;
	logic [2:0][CW-1:0]  chan_s4;
	logic [CW-1:0]       luma_s4, w_shadow_s4, w_mid_s4, w_high_s4;

	cbz_luma #(.FRAC_BITS(FRAC_BITS)) u_luma (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.in_valid    (upstream.valid),
		.red         (upstream.red_in),
		.green       (upstream.green_in),
		.blue        (upstream.blue_in),
		.valid_s4    (valid_s4),
		.chan_s4     (chan_s4),
		.luma_s4     (luma_s4),
		.w_shadow_s4 (w_shadow_s4),
		.w_mid_s4    (w_mid_s4),
		.w_high_s4   (w_high_s4)
	);

	// Stages 5-9: gains, new luma and the rescale decision
	logic                valid_s9;
	logic [2:0][AW-1:0]  adj_s9;
	logic [CW-1:0]       luma_s9;
	logic [NDW-1:0]      den_s9;
	logic                rescale_s9;

	cbz_adjust #(.FRAC_BITS(FRAC_BITS)) u_adjust (
		.clk         (clk),
		.arst_n      (arst_n),
		.en          (advance),
		.cfg         (cfg_q),
		.valid_s4    (valid_s4),
		.chan_s4     (chan_s4),
		.luma_s4     (luma_s4),
		.w_shadow_s4 (w_shadow_s4),
		.w_mid_s4    (w_mid_s4),
		.w_high_s4   (w_high_s4),
		.valid_s9    (valid_s9),
		.adj_s9      (adj_s9),
		.luma_s9     (luma_s9),
		.den_s9      (den_s9),
		.rescale_s9  (rescale_s9)
	);

	// Scale factor old luma / new luma; adjusted channels ride alongside.
	// The quotient is garbage when no rescale is due and is then ignored.
	logic              div_valid;
	logic [QW-1:0]     quot;
	logic [SIDE_W-1:0] side_in, side_out;

	assign side_in = {rescale_s9, adj_s9};

	cbz_div #(.FRAC_BITS(FRAC_BITS), .SIDE_W(SIDE_W)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (advance),
		.in_valid  (valid_s9),
		.luma      (luma_s9),
		.den       (den_s9),
		.side_in   (side_in),
		.out_valid (div_valid),
		.quot      (quot),
		.side_out  (side_out)
	);

	// Rescale multiply, clamp, output register and skid slot
	logic [2:0][7:0] out_pix;

	cbz_out #(.FRAC_BITS(FRAC_BITS)) u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (div_valid),
		.quot      (quot),
		.adj       (side_out[3*AW-1:0]),
		.rescale   (side_out[SIDE_W-1]),
		.out_ready (downstream.ready),
		.advance   (advance),
		.out_valid (downstream.valid),
		.out_pix   (out_pix)
	);

	assign downstream.red_out   = out_pix[0];
	assign downstream.green_out = out_pix[1];
	assign downstream.blue_out  = out_pix[2];

endmodule
`default_nettype wire

### src/cbz_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Color balance port checker
// Watches the pixel channels: output stability, no invented results, stalls.
// ----------------------------------------------------------------------------
module cbz_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       up_valid,
	input wire logic       up_ready,
	input wire logic       dn_valid,
	input wire logic       dn_ready,
	input wire logic [7:0] red_out,
	input wire logic [7:0] green_out,
	input wire logic [7:0] blue_out
);
	// Transactions accepted but not yet delivered
	logic [7:0] pend_q;
	logic       up_acc, dn_acc;

	assign up_acc = up_valid && up_ready;
	assign dn_acc = dn_valid && dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + 8'(up_acc) - 8'(dn_acc);
		end
	end

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		dn_valid && !dn_ready |=> dn_valid && $stable(red_out) && $stable(green_out)
			&& $stable(blue_out))
		else $error("output changed while stalled");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q == 8'd0 |-> !dn_valid)
		else $error("result without a pending input");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!up_ready |-> dn_valid)
		else $error("input held off with no result waiting");

endmodule

bind color_balance_three_zone_rgb cbz_checker u_cbz_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.up_valid  (upstream.valid),
	.up_ready  (upstream.ready),
	.dn_valid  (downstream.valid),
	.dn_ready  (downstream.ready),
	.red_out   (downstream.red_out),
	.green_out (downstream.green_out),
	.blue_out  (downstream.blue_out)
);
`default_nettype wire

### bench/tb_color_balance_three_zone_rgb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Color balance three-zone testbench
// Drives pixels through the valid/ready channels under random idling on both
// sides, predicts adjusted pixels in fixed point or takes a typed expectation, and compares in order.
// ----------------------------------------------------------------------------
module tb_color_balance_three_zone_rgb;
	import cbz_pkg::*;

	localparam int FB = FRAC_BITS_DEF;
	localparam longint UNIT = longint'(1) << FB;
	localparam int LATENCY = FB + 21;
	localparam int N_RANDOM = 1650;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pixel_t;

	// directed row: pixel plus an optional hand-typed expectation
	typedef struct {
		pixel_t pix;
		bit     typed;
		pixel_t want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	cbz_pix_in_if  pin();
	cbz_pix_out_if pout();
	cbz_cfg_if     cfgc();

	color_balance_three_zone_rgb dut (
		.clk(clk), .arst_n(arst_n),
		.upstream(pin.sink), .downstream(pout.source), .cfg(cfgc.sink)
	);

	// shadow of the block's registers for the predictor
	logic [23:0] gain_shadow, gain_mid, gain_high;
	logic        keep_luma;

	pixel_t pending_pixels[$];
	int     errors = 0;
	int     sent = 0;
	int     received = 0;
	bit     quiet_tail = 1'b0;
	longint cycles = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	// Watchdog: count cycles and abort well past the slowest legal run.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d pixels outstanding",
				cycles, pending_pixels.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic longint pct_gain(logic [23:0] packed_g, int ch);
		return longint'($signed(packed_g[8*ch +: 8]));
	endfunction

	function automatic longint luma_fx(longint c0, longint c1, longint c2);
		return (299 * c0 + 587 * c1 + 114 * c2) / 1000;
	endfunction

	// Balance one pixel with the current register copy.
	function automatic pixel_t balance_pixel(pixel_t p);
		longint c[3];
		longint lum, t, d, ws, wm, wh, nl, s, v, sum;
		logic [7:0] px[3];
		pixel_t res;
		px[0] = p.r; px[1] = p.g; px[2] = p.b;
		for (int i = 0; i < 3; i++)
			c[i] = (longint'(px[i]) * UNIT + 254) / 255;
		lum = luma_fx(c[0], c[1], c[2]);
		t = (5 * lum) / 2;
		d = lum - UNIT / 2;
		if (d < 0) d = -d;
		ws = (UNIT - t) > 0 ? UNIT - t : 0;
		wm = (UNIT - 3 * d) > 0 ? UNIT - 3 * d : 0;
		wh = (t - (3 * UNIT) / 2) > 0 ? t - (3 * UNIT) / 2 : 0;
		for (int i = 0; i < 3; i++) begin
			sum = pct_gain(gain_shadow, i) * ws + pct_gain(gain_mid, i) * wm
				+ pct_gain(gain_high, i) * wh;
			c[i] += sum / 100;
		end
		if (keep_luma) begin
			nl = luma_fx(c[0], c[1], c[2]);
			// skip the rescale when the adjusted pixel is nearly black
			if (nl > UNIT / 1000 && nl > 0) begin
				s = (lum * UNIT) / nl;
				for (int i = 0; i < 3; i++)
					c[i] = (c[i] * s) / UNIT;
			end
		end
		for (int i = 0; i < 3; i++) begin
			v = c[i] * 255;
			if (v <= 0) px[i] = 8'd0;
			else if ((v >>> FB) > 255) px[i] = 8'hFF;
			else px[i] = 8'(v >>> FB);
		end
		res.r = px[0]; res.g = px[1]; res.b = px[2];
		return res;
	endfunction

	// Output side: random ready bursts, compare each transaction in order.
	initial begin
		pout.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				pout.ready <= 1'b0;
				repeat ($urandom_range(1, 3)) @(negedge clk);
			end
			pout.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		pixel_t want;
		if (arst_n && pout.valid && pout.ready) begin
			received++;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel %h %h %h", $time,
					pout.red_out, pout.green_out, pout.blue_out);
				errors++;
			end else begin
				want = pending_pixels.pop_front();
				if (want.r !== pout.red_out) begin
					$display("%0t: red expected %0d got %0d", $time, want.r, pout.red_out);
					errors++;
				end
				if (want.g !== pout.green_out) begin
					$display("%0t: green expected %0d got %0d", $time, want.g,
						pout.green_out);
					errors++;
				end
				if (want.b !== pout.blue_out) begin
					$display("%0t: blue expected %0d got %0d", $time, want.b,
						pout.blue_out);
					errors++;
				end
			end
		end
	end

	// Write one register through the config channel; block must be idle.
	// Valid stays high into the next write; the caller drops it at the end.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		cfgc.valid <= 1'b1;
		cfgc.index <= idx;
		cfgc.data  <= val;
		@(posedge clk);
		while (!cfgc.ready) @(posedge clk);
		case (idx)
			REG_SHADOW:    gain_shadow = val;
			REG_MIDTONE:   gain_mid = val;
			REG_HIGHLIGHT: gain_high = val;
			REG_PRESERVE:  keep_luma = val[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic set_gains(logic [23:0] sh, logic [23:0] md, logic [23:0] hi, logic keep);
		write_reg(REG_SHADOW, sh);
		write_reg(REG_MIDTONE, md);
		write_reg(REG_HIGHLIGHT, hi);
		write_reg(REG_PRESERVE, {23'($urandom), keep});
		cfgc.valid <= 1'b0;
	endtask

	// Send one pixel; the expectation is queued at acceptance.
	task automatic push_pixel(pixel_t p, bit typed, pixel_t want);
		if (!quiet_tail && $urandom_range(0, 5) == 0) begin
			pin.valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		pin.valid    <= 1'b1;
		pin.red_in   <= p.r;
		pin.green_in <= p.g;
		pin.blue_in  <= p.b;
		@(posedge clk);
		while (!pin.ready) @(posedge clk);
		pending_pixels.push_back(typed ? want : balance_pixel(p));
		sent++;
		@(negedge clk);
	endtask

	task automatic drain();
		pin.valid <= 1'b0;
		while (pending_pixels.size() != 0) @(negedge clk);
		repeat (LATENCY + 4) @(negedge clk);
	endtask

	function automatic pixel_t rand_pixel();
		pixel_t p;
		p = pixel_t'($urandom);
		case ($urandom_range(0, 5))
			0: p = {3{8'($urandom_range(0, 40))}};
			1: p = {3{8'($urandom_range(215, 255))}};
			2: p.g = 8'($urandom_range(100, 155));
			default: ;
		endcase
		return p;
	endfunction

	function automatic logic [23:0] rand_gains();
		logic [23:0] g;
		for (int i = 0; i < 3; i++)
			g[8*i +: 8] = ($urandom_range(0, 7) == 0) ? 8'($urandom)
				: 8'($signed($urandom_range(0, 200)) - 100);
		return g;
	endfunction

	row_t rows[$];

	initial begin
		row_t rw;
		pixel_t none;
		none = '0;
		pin.valid = 1'b0; pin.red_in = '0; pin.green_in = '0; pin.blue_in = '0;
		cfgc.valid = 1'b0; cfgc.index = '0; cfgc.data = '0;
		gain_shadow = '0; gain_mid = '0; gain_high = '0; keep_luma = PRESERVE_RST;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// After reset: zero gains return the pixel unchanged.
		rows = '{
			'{'{8'h00, 8'h00, 8'h00}, 1, '{8'h00, 8'h00, 8'h00}},
			'{'{8'hFF, 8'hFF, 8'hFF}, 1, '{8'hFF, 8'hFF, 8'hFF}},
			'{'{8'hFF, 8'h00, 8'h00}, 1, '{8'hFF, 8'h00, 8'h00}},
			'{'{8'h00, 8'hFF, 8'h00}, 1, '{8'h00, 8'hFF, 8'h00}},
			'{'{8'h00, 8'h00, 8'hFF}, 1, '{8'h00, 8'h00, 8'hFF}},
			'{'{8'h55, 8'hAA, 8'h5A}, 1, '{8'h55, 8'hAA, 8'h5A}}
		};
		foreach (rows[i]) push_pixel(rows[i].pix, rows[i].typed, rows[i].want);
		drain();

		// Extreme gains, including out-of-range signed values; luma kept.
		set_gains(24'h7F8064, 24'h9C6480, 24'h80_7F_9C, 1'b1);
		rows = '{
			'{'{8'h00, 8'h00, 8'h00}, 0, none},
			'{'{8'h01, 8'h01, 8'h01}, 0, none},
			'{'{8'h20, 8'h10, 8'h08}, 0, none},
			'{'{8'h80, 8'h80, 8'h80}, 0, none},
			'{'{8'hFF, 8'hFF, 8'hFF}, 0, none},
			'{'{8'hE0, 8'hF0, 8'hC0}, 0, none},
			'{'{8'h66, 8'h66, 8'h66}, 0, none}
		};
		foreach (rows[i]) push_pixel(rows[i].pix, rows[i].typed, rows[i].want);
		drain();

		// Strong darkening drives the adjusted luma to the dark threshold.
		set_gains(24'h9C9C9C, 24'h9C9C9C, 24'h9C9C9C, 1'b1);
		rows = '{
			'{'{8'h03, 8'h03, 8'h03}, 0, none},
			'{'{8'h30, 8'h30, 8'h30}, 0, none},
			'{'{8'hFF, 8'h00, 8'hFF}, 0, none}
		};
		foreach (rows[i]) push_pixel(rows[i].pix, rows[i].typed, rows[i].want);
		drain();

		// Preserve off: full boost saturates, full cut clamps to zero.
		set_gains(24'h646464, 24'h7F7F7F, 24'h646464, 1'b0);
		rows = '{
			'{'{8'hFF, 8'hFF, 8'hFF}, 1, '{8'hFF, 8'hFF, 8'hFF}},
			'{'{8'h80, 8'h80, 8'h80}, 0, none},
			'{'{8'h10, 8'h40, 8'h00}, 0, none}
		};
		foreach (rows[i]) push_pixel(rows[i].pix, rows[i].typed, rows[i].want);
		drain();
		set_gains(24'h9C9C9C, 24'h808080, 24'h9C9C9C, 1'b0);
		rows = '{
			'{'{8'h00, 8'h00, 8'h00}, 1, '{8'h00, 8'h00, 8'h00}},
			'{'{8'hFF, 8'hFF, 8'hFF}, 0, none},
			'{'{8'h7F, 8'h80, 8'h81}, 0, none}
		};
		foreach (rows[i]) push_pixel(rows[i].pix, rows[i].typed, rows[i].want);
		drain();

		// Random phases: fresh gains each phase, silent tail in the last.
		for (int ph = 0; ph < 11; ph++) begin
			set_gains(rand_gains(), rand_gains(), rand_gains(), 1'($urandom));
			if (ph == 10) quiet_tail = 1'b1;
			for (int k = 0; k < N_RANDOM / 11; k++)
				push_pixel(rand_pixel(), 0, none);
			drain();
		end

		$display("covered %0d pixels sent, %0d checked, across 16 gain settings",
			sent, received);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
